FILE: hw/rtl/twcr_pkg.sv
// Package for the textured wall column renderer.
// Holds register indexes, request kinds, the shading mask, the sequencer state type and the payload structs.
package twcr_pkg;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_CEILING = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR   = 1'b1;
	localparam logic [23:0] HALF_MASK = 24'd8355711;
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_DRAW = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIVH = 5'b00010,
		ST_DIVS = 5'b00100,
		ST_INIT = 5'b01000,
		ST_ROWS = 5'b10000
	} state_t;

	typedef struct packed {
		logic        kind;
		logic [1:0]  texture_select;
		logic [11:0] texel_index;
		logic [23:0] texel_color;
		logic [9:0]  column;
		logic [23:0] wall_distance;
		logic        hit_side;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic [21:0] pos_x;
		logic [21:0] pos_y;
	} req_t;

	typedef struct packed {
		logic [9:0]  out_column;
		logic [5:0]  row;
		logic [23:0] pixel_color;
		logic        last;
	} pix_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [23:0]          data;
	} cfg_t;
endpackage

FILE: hw/rtl/twcr_if.sv
// Valid/ready channel interfaces for the renderer.
// Depends on twcr_pkg for payload types.
interface twcr_req_if;
	logic valid;
	logic ready;
	twcr_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface twcr_pix_if;
	logic valid;
	logic ready;
	twcr_pkg::pix_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface twcr_cfg_if;
	logic valid;
	logic ready;
	twcr_pkg::cfg_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/textured_wall_column_renderer_unit.sv
// A load is written to texture memory when it is taken. A draw runs two 32-step restoring divisions
// (one quotient bit a cycle in a shared unit) and a setup state. It then issues SCREEN_ROWS
// reads, one per cycle while the output does not stall, into a 2-stage read/output pipe.
// Throughput: one request at a time. The input reopens once the column's last pixel has left.
// arst_n clears control state and the color registers; texture memory is undefined until written.
module textured_wall_column_renderer_unit #(
	parameter int SCREEN_ROWS = 64,
	parameter int TEX_SIZE = 64,
	parameter int NUM_TEXTURES = 4
) (
	input  logic clk,
	input  logic arst_n,
	twcr_req_if.sink   req,
	twcr_pix_if.source pix,
	twcr_cfg_if.sink   cfg
);
	import twcr_pkg::*;

	localparam int TB = $clog2(TEX_SIZE);
	localparam int AW = $clog2(NUM_TEXTURES) + 2 * TB;
	localparam int RB = $clog2(SCREEN_ROWS);
	localparam int MID = SCREEN_ROWS / 2;
	localparam int DW = 32; // dividend width covers 64<<16 and 256<<16
	localparam int LW = 24; // height fits in 24 bits

	logic [23:0] tex_mem [NUM_TEXTURES*TEX_SIZE*TEX_SIZE];
	logic [23:0] ceil_q, floor_q;
	state_t st_q;

	req_t r_q;
	logic [DW-1:0] dvd_q, quo_q;
	logic [DW:0] rem_q;
	logic [DW-1:0] dvs_q;
	logic [5:0] bit_q;
	logic [LW-1:0] lh_q;
	logic [DW-1:0] step_q, tpos_q;
	logic [TB-1:0] tx_q;
	logic [1:0] tex_q;
	logic signed [RB+1:0] start_q, end_q;
	logic [RB:0] y_q;

	// pixel pipeline: s1 memory data back, s2 shaded into the output register
	logic v_s1;
	logic [RB-1:0] y_s1;
	logic wall_s1;
	logic [23:0] mdat_s1;
	logic [23:0] rd_s2;
	logic ov_q;
	pix_t od_q;
	logic wall_s2;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ceil_q <= '0;
			floor_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				REG_CEILING: ceil_q <= cfg.data.data;
				REG_FLOOR: floor_q <= cfg.data.data;
				default: ;
			endcase
		end
	end

	// r_q feeds the pixel pipe, so hold the input until the pipe is empty
	assign req.ready = (st_q == ST_IDLE) && !v_s1 && !ov_q;
	wire acc = req.valid && req.ready;

	// pipeline advances when the output register is free or drained
	wire adv = !ov_q || pix.ready;

	logic [DW:0] trial;
	assign trial = {rem_q[DW-1:0], dvd_q[DW-1]} - {1'b0, dvs_q};
	logic [DW-1:0] q_nx;
	assign q_nx = {quo_q[DW-2:0], !trial[DW]};

	// hit fraction
	logic [21:0] posq;
	logic signed [15:0] dirq;
	logic [23:0] wd;
	logic signed [40:0] prod;
	logic [29:0] frac;
	logic [TB-1:0] txr;
	always_comb begin
		posq = r_q.hit_side ? r_q.pos_x : r_q.pos_y;
		dirq = r_q.hit_side ? r_q.dir_x : r_q.dir_y;
		// zero distance counts as one LSB
		wd = (r_q.wall_distance == 24'd0) ? 24'd1 : r_q.wall_distance;
		prod = $signed({17'd0, wd}) * 41'(dirq);
		frac = 30'({posq, 14'd0}) + prod[29:0];
		txr = frac[29 -: TB];
	end

	wire [LW-1:0] half = lh_q >> 1;
	wire signed [RB+1:0] half_c = (half > LW'(MID)) ? (RB+2)'(MID) : (RB+2)'(half);
	wire signed [RB+1:0] st_c = (RB+2)'(MID) - half_c;
	wire signed [RB+1:0] en_c = ((RB+2)'(MID) + half_c > (RB+2)'(SCREEN_ROWS-1)) ?
		(RB+2)'(SCREEN_ROWS-1) : (RB+2)'(MID) + half_c;
	// start - MID + half is zero unless clipped, then half - MID
	wire [LW-1:0] toff = (half > LW'(MID)) ? half - LW'(MID) : '0;
	logic [LW+DW-1:0] tp0;
	assign tp0 = toff * step_q;

	wire in_rows = (st_q == ST_ROWS) && adv;
	wire signed [RB+1:0] ys = (RB+2)'(y_q);
	wire is_wall = (ys >= start_q) && (ys <= end_q);
	wire [TB-1:0] ty = tpos_q[16 +: TB];
	wire [AW-1:0] raddr = AW'({tex_q, ty, tx_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			bit_q <= '0;
			y_q <= '0;
		end else begin
			case (st_q)
				ST_IDLE: if (acc && req.data.kind == KIND_DRAW) begin
					st_q <= ST_DIVH;
					bit_q <= 6'(DW);
				end
				ST_DIVH: begin
					if (bit_q == 6'd1) begin
						st_q <= ST_DIVS;
						bit_q <= 6'(DW);
					end else bit_q <= bit_q - 6'd1;
				end
				ST_DIVS: begin
					if (bit_q == 6'd1) st_q <= ST_INIT;
					else bit_q <= bit_q - 6'd1;
				end
				ST_INIT: begin
					st_q <= ST_ROWS;
					y_q <= '0;
				end
				ST_ROWS: if (adv) begin
					if (y_q == (RB+1)'(SCREEN_ROWS-1)) st_q <= ST_IDLE;
					y_q <= y_q + 1'b1;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			r_q <= req.data;
			if (req.data.kind == KIND_LOAD)
				tex_mem[AW'({req.data.texture_select, (2*TB)'(req.data.texel_index)})]
					<= req.data.texel_color;
			dvd_q <= DW'(SCREEN_ROWS) << 16;
			dvs_q <= (req.data.wall_distance == 0) ? DW'(1) : DW'(req.data.wall_distance);
			rem_q <= '0;
			quo_q <= '0;
		end else if (st_q == ST_DIVH && bit_q == 6'd1) begin
			// height done: set up the step division
			lh_q <= LW'(q_nx);
			dvd_q <= DW'(TEX_SIZE) << 16;
			dvs_q <= (q_nx == 0) ? DW'(1) : q_nx;
			rem_q <= '0;
			quo_q <= '0;
		end else if (st_q == ST_DIVH || st_q == ST_DIVS) begin
			dvd_q <= dvd_q << 1;
			if (!trial[DW]) begin
				rem_q <= trial;
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DW-1:0], dvd_q[DW-1]};
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
			if (st_q == ST_DIVS && bit_q == 6'd1)
				step_q <= (lh_q == 0) ? '0 : q_nx;
		end else if (st_q == ST_INIT) begin
			start_q <= st_c;
			end_q <= en_c;
			tpos_q <= DW'(tp0);
			tx_q <= (((!r_q.hit_side) && r_q.dir_x > 0) || (r_q.hit_side && r_q.dir_y < 0)) ?
				TB'(TEX_SIZE - 1) - txr : txr;
			tex_q <= r_q.hit_side ? ((r_q.dir_y > 0) ? 2'd0 : 2'd1) :
				((r_q.dir_x > 0) ? 2'd2 : 2'd3);
		end else if (in_rows && is_wall) begin
			tpos_q <= tpos_q + step_q;
		end
		if (in_rows) begin
			mdat_s1 <= tex_mem[raddr];
			y_s1 <= y_q[RB-1:0];
			wall_s1 <= is_wall;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			ov_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_rows;
			ov_q <= v_s1;
		end
	end

	always_comb begin
		rd_s2 = r_q.hit_side ? ((mdat_s1 >> 1) & HALF_MASK) : mdat_s1;
		wall_s2 = wall_s1;
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			od_q.out_column <= r_q.column;
			od_q.row <= 6'(y_s1);
			od_q.last <= (y_s1 == RB'(SCREEN_ROWS-1));
			od_q.pixel_color <= wall_s2 ? rd_s2 :
				((y_s1 < RB'(MID)) ? ceil_q : floor_q);
		end
	end

	assign pix.valid = ov_q;
	assign pix.data = od_q;
endmodule

FILE: hw/rtl/twcr_checker.sv
// Port-level checks for the renderer, bound to the top level.
// Depends on twcr_pkg via the top level's interfaces.
module twcr_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic pix_valid,
	input logic pix_ready,
	input logic [5:0] row,
	input logic last
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_ready |=> pix_valid) else $error("pixel dropped");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && last |-> row != 6'd0) else $error("last on top row");
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready && !last |=> !req_ready) else $error("request taken mid column");
	a_row0: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready && last |=> !pix_valid) else $error("extra pixel");
endmodule

bind textured_wall_column_renderer_unit twcr_checker u_chk (
	.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
	.pix_valid(pix.valid), .pix_ready(pix.ready), .row(pix.data.row), .last(pix.data.last)
);

FILE: tb/twcr_tb_if.sv
// Note: the channel interfaces come from the RTL (hw/rtl/twcr_if.sv).
// This file sets the time unit, defines the directed-table row type and is compiled after twcr_pkg.
`timescale 1ns / 1ps
package twcr_tb_types;
	import twcr_pkg::*;
	// One row of the directed table; want_color < 0 means "use the predictor".
	typedef struct {
		req_t req;
		int   want_color;
	} dir_row_t;
endpackage

FILE: tb/textured_wall_column_renderer_unit_test.sv
// Testbench for textured_wall_column_renderer_unit: loads textures, draws columns,
// checks every pixel against a local column predictor. Depends on twcr_pkg, twcr_tb_types, twcr_if.
`timescale 1ns / 1ps
module textured_wall_column_renderer_unit_test;
	import twcr_pkg::*;
	import twcr_tb_types::*;

	localparam int ROWS = 64;
	localparam int TSZ = 64;
	localparam int AREA = TSZ * TSZ;

	logic clk;
	logic arst_n;
	twcr_req_if req ();
	twcr_pix_if pix ();
	twcr_cfg_if cfg ();

	textured_wall_column_renderer_unit #(.SCREEN_ROWS(ROWS), .TEX_SIZE(TSZ), .NUM_TEXTURES(4)) dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .pix(pix.source), .cfg(cfg.sink)
	);

	logic [23:0] tex_mem [0:4*AREA-1];
	bit          tex_written [0:4*AREA-1];
	logic [23:0] ceil_reg, floor_reg;
	pix_t        pixel_queue[$];
	int          err_count;
	bit          hold_off;
	int          stall_force;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("textured_wall_column_renderer_unit_test: FAIL");
		$finish;
	end

	task automatic report(input string what);
		err_count++;
		$display("mismatch: %s", what);
	endtask

	// Works out the pixels of one draw request and queues them.
	function automatic void predict_column(input req_t r);
		logic [63:0] dval, lh, half, step, tpos, posq, hitq, frac, tx, ty;
		longint start, stop, dq;
		int tex;
		logic [23:0] c;
		pix_t p;
		dval = r.wall_distance;
		if (dval == 0) dval = 1;
		lh = (64'(ROWS) << 16) / dval;
		half = lh / 2;
		start = ROWS / 2 - longint'(half);
		if (start < 0) start = 0;
		stop = longint'(half) + ROWS / 2;
		if (stop > ROWS - 1) stop = ROWS - 1;
		if (r.hit_side) tex = (r.dir_y > 0) ? 0 : 1;
		else tex = (r.dir_x > 0) ? 2 : 3;
		posq = r.hit_side ? 64'(r.pos_x) : 64'(r.pos_y);
		dq = r.hit_side ? longint'(r.dir_x) : longint'(r.dir_y);
		hitq = (posq << 14) + 64'(longint'(dval) * dq);
		frac = hitq & ((64'd1 << 30) - 1);
		tx = (frac * TSZ) >> 30;
		if ((!r.hit_side && r.dir_x > 0) || (r.hit_side && r.dir_y < 0)) tx = TSZ - 1 - tx;
		step = (lh == 0) ? 0 : ((64'(TSZ) << 16) / lh);
		tpos = 64'(start - ROWS / 2 + longint'(half)) * step;
		for (int y = 0; y < ROWS; y++) begin
			if (y >= start && y <= stop) begin
				ty = (tpos >> 16) % TSZ;
				tpos += step;
				c = tex_mem[tex * AREA + ty * TSZ + tx];
				if (r.hit_side) c = (c >> 1) & HALF_MASK;
			end else if (y < ROWS / 2) begin
				c = ceil_reg;
			end else begin
				c = floor_reg;
			end
			p.out_column = r.column;
			p.row = y[5:0];
			p.pixel_color = c;
			p.last = (y == ROWS - 1);
			pixel_queue.push_back(p);
		end
	endfunction

	// Does every texel this draw may fetch exist? (column fixed by position, every row checked)
	function automatic bit column_loaded(input req_t r);
		int tex;
		logic [63:0] posq, hitq, frac, tx;
		longint dq;
		logic [63:0] dval;
		dval = r.wall_distance;
		if (dval == 0) dval = 1;
		if (r.hit_side) tex = (r.dir_y > 0) ? 0 : 1;
		else tex = (r.dir_x > 0) ? 2 : 3;
		posq = r.hit_side ? 64'(r.pos_x) : 64'(r.pos_y);
		dq = r.hit_side ? longint'(r.dir_x) : longint'(r.dir_y);
		hitq = (posq << 14) + 64'(longint'(dval) * dq);
		frac = hitq & ((64'd1 << 30) - 1);
		tx = (frac * TSZ) >> 30;
		if ((!r.hit_side && r.dir_x > 0) || (r.hit_side && r.dir_y < 0)) tx = TSZ - 1 - tx;
		for (int y = 0; y < TSZ; y++)
			if (!tex_written[tex * AREA + y * TSZ + tx]) return 0;
		return 1;
	endfunction

	function automatic int short_or_long_gap();
		return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) :
		       ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3);
	endfunction

	// Result side: random stalls, plus a long forced hold-off when asked.
	always @(negedge clk) begin
		if (!arst_n) begin
			pix.ready <= 1'b0;
		end else if (hold_off) begin
			pix.ready <= 1'b0;
		end else if (stall_force > 0) begin
			stall_force <= stall_force - 1;
			pix.ready <= 1'b0;
		end else begin
			pix.ready <= ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 40) == 0) stall_force <= short_or_long_gap();
		end
	end

	always @(posedge clk) begin
		if (arst_n && pix.valid && pix.ready) begin
			if (pixel_queue.size() == 0) begin
				report($sformatf("unexpected pixel col %0d row %0d", pix.data.out_column,
					pix.data.row));
			end else begin
				pix_t e;
				e = pixel_queue.pop_front();
				if (pix.data.out_column !== e.out_column)
					report($sformatf("column got %0d want %0d", pix.data.out_column, e.out_column));
				if (pix.data.row !== e.row)
					report($sformatf("row got %0d want %0d", pix.data.row, e.row));
				if (pix.data.pixel_color !== e.pixel_color)
					report($sformatf("color col %0d row %0d got %h want %h", e.out_column, e.row,
						pix.data.pixel_color, e.pixel_color));
				if (pix.data.last !== e.last)
					report($sformatf("last row %0d got %b", e.row, pix.data.last));
			end
		end
	end

	// Valid stays up after an accept so back-to-back requests need no gap;
	// drain() drops it.
	task automatic send_request(input req_t r);
		int gap;
		gap = short_or_long_gap();
		@(negedge clk);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.data <= r;
		req.valid <= 1'b1;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		if (r.kind == KIND_LOAD) begin
			tex_mem[r.texture_select * AREA + r.texel_index % AREA] = r.texel_color;
			tex_written[r.texture_select * AREA + r.texel_index % AREA] = 1;
		end else begin
			predict_column(r);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] v);
		@(negedge clk);
		cfg.data.index <= idx;
		cfg.data.data <= v;
		cfg.valid <= 1'b1;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		if (idx == REG_CEILING) ceil_reg = v;
		else floor_reg = v;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic drain();
		@(negedge clk);
		req.valid <= 1'b0;
		while (pixel_queue.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	function automatic req_t load_req(input int sel, input int idx, input logic [23:0] c);
		req_t r;
		r = '0;
		r.kind = KIND_LOAD;
		r.texture_select = sel[1:0];
		r.texel_index = idx[11:0];
		r.texel_color = c;
		r.column = 10'($urandom());
		r.wall_distance = 24'($urandom());
		return r;
	endfunction

	function automatic req_t draw_req(input int d, input bit side, input int dx, input int dy,
			input int px, input int py);
		req_t r;
		r = '0;
		r.kind = KIND_DRAW;
		r.texture_select = 2'($urandom());
		r.texel_index = 12'($urandom());
		r.texel_color = 24'($urandom());
		r.column = 10'($urandom());
		r.wall_distance = d[23:0];
		r.hit_side = side;
		r.dir_x = dx[15:0];
		r.dir_y = dy[15:0];
		r.pos_x = px[21:0];
		r.pos_y = py[21:0];
		return r;
	endfunction

	// Random hits, kept to texture columns that have been loaded.
	function automatic req_t random_draw();
		int d;
		req_t r;
		do begin
			case ($urandom_range(0, 3))
				0: d = $urandom_range(0, 16'hffff);
				1: d = $urandom_range(16'hffff, 24'h7ffff);
				2: d = $urandom_range(0, 24'hffffff);
				default: d = $urandom_range(24'h40000, 24'hffffff);
			endcase
			r = draw_req(d, 1'($urandom()), $urandom(), $urandom(), $urandom(), $urandom());
		end while (!column_loaded(r));
		return r;
	endfunction

	dir_row_t dir_rows[$];

	initial begin
		req_t r;
		int sent;
		logic [23:0] tc;
		arst_n = 0;
		req.valid = 0;
		req.data = '0;
		cfg.valid = 0;
		cfg.data = '0;
		ceil_reg = 0;
		floor_reg = 0;
		hold_off = 0;
		err_count = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Load the columns that draws land on: column 0 of textures 0, 1, 3
		// and the last column of textures 1, 2 (mirrored hits).
		for (int y = 0; y < TSZ; y++) begin
			tc = (y == 5) ? 24'hffffff : 24'($urandom());
			send_request(load_req(0, y * TSZ, tc));
			send_request(load_req(1, y * TSZ, 24'($urandom())));
			send_request(load_req(1, y * TSZ + TSZ - 1, 24'($urandom())));
			send_request(load_req(2, y * TSZ + TSZ - 1, tc));
			send_request(load_req(3, y * TSZ, 24'($urandom())));
		end

		// Directed: want_color is the top row where it is known at a glance.
		// After reset a huge distance gives zero height and a zero ceiling.
		dir_rows.push_back('{draw_req(24'hffffff, 0, 1, 1, 0, 0), 0});
		dir_rows.push_back('{draw_req(0, 0, 16'h7fff, 16'h8000, 22'h3fffff, 2), -1});
		dir_rows.push_back('{draw_req(0, 1, 16'h8000, 16'h7fff, 2, 0), -1});
		dir_rows.push_back('{draw_req(1 << 16, 1, 100, 0, 0, 99999), -1});
		dir_rows.push_back('{draw_req(1 << 16, 0, 0, 100, 77777, 0), -1});
		dir_rows.push_back('{draw_req(1 << 20, 1, -5, -7, 1000, 2000), -1});
		dir_rows.push_back('{draw_req(1 << 20, 0, 5, -7, 1000, 1000), -1});
		dir_rows.push_back('{draw_req(3 << 15, 1, 3, 9, 500, 600), -1});
		dir_rows.push_back('{draw_req(2 << 16, 0, -3, 9, 500, 600), -1});
		// last texel of the last texture
		dir_rows.push_back('{load_req(3, 4095, 24'h123456), -1});
		foreach (dir_rows[i]) begin
			if (dir_rows[i].req.kind == KIND_DRAW && !column_loaded(dir_rows[i].req))
				report($sformatf("directed row %0d hits an unloaded column", i));
			send_request(dir_rows[i].req);
			// this column's pixels are still the last ROWS entries
			if (dir_rows[i].want_color >= 0 &&
			    pixel_queue[pixel_queue.size() - ROWS].pixel_color !==
			    24'(dir_rows[i].want_color))
				report($sformatf("directed row %0d top pixel", i));
		end
		drain();

		write_reg(REG_CEILING, 24'hffffff);
		write_reg(REG_FLOOR, 24'h000000);
		send_request(draw_req(24'hffffff, 0, 1, 1, 0, 0));
		drain();
		write_reg(REG_CEILING, 24'h000000);
		write_reg(REG_FLOOR, 24'hffffff);
		send_request(draw_req(24'h800000, 1, 1, 1, 0, 0));

		// Long receiver hold-off while requests keep coming.
		hold_off = 1;
		fork
			begin
				repeat (400) @(negedge clk);
				hold_off = 0;
			end
			for (int i = 0; i < 4; i++) send_request(random_draw());
		join
		drain();

		sent = 0;
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(REG_CEILING, 24'($urandom()));
			write_reg(REG_FLOOR, 24'($urandom()));
			for (int i = 0; i < 19; i++) begin
				if ($urandom_range(0, 4) == 0)
					r = load_req($urandom_range(0, 3), $urandom(), 24'($urandom()));
				else
					r = random_draw();
				send_request(r);
				sent++;
			end
			drain();
		end

		$display("");
		if (err_count == 0) begin
			$display("textured_wall_column_renderer_unit_test: PASS");
		end else begin
			$display("textured_wall_column_renderer_unit_test: FAIL");
		end
		$finish;
	end
endmodule
